@@ rtl/sorted_table_binary_search_assert.svh @@
// assertion macros for the sorted table search block
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication
`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stbs_pkg.sv @@
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ID_WIDTH    = 32;

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int SPAN_W  = $clog2(TABLE_DEPTH + 1);
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int KEY_W   = 32;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [SPAN_W-1:0]   span_t;
	typedef logic [ID_WIDTH-1:0] id_t;

	localparam span_t DEPTH_SPAN = span_t'(TABLE_DEPTH);

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	// floor((lo + hi) / 2) with the upper bound held as hi + 1
	function automatic addr_t mid_of(span_t lo, span_t hp1);
		logic [SPAN_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hp1} - {{SPAN_W{1'b0}}, 1'b1};
		return addr_t'(sum >> 1);
	endfunction

endpackage

@@ rtl/stbs_table.sv @@
module stbs_table (
	input  logic            clk,
	input  logic            wr_en,
	input  stbs_pkg::addr_t wr_addr,
	input  stbs_pkg::id_t   wr_data,
	input  stbs_pkg::addr_t rd_addr,
	output stbs_pkg::id_t   rd_data
);
	import stbs_pkg::*;

	id_t mem [TABLE_DEPTH];
	id_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// channel   | signals                                      | transfer
// ----------+----------------------------------------------+--------------------------
// command   | start, busy, action, entry_index, entry_id,  | start high, busy low
//           | search_id                                    |
// config    | cfg_valid, cfg_ready, cfg_data               | cfg_valid and cfg_ready
// result    | done, found, match_index                     | done high, one cycle
//
// a load never raises busy; a search holds busy while it probes, at most
// ceil(log2(count + 1)) probes (11 for 1024 entries), and done follows the last probe
// each probe is one table read plus the compare that picks the next address
// an empty search gives done in the cycle after the transfer with busy staying low
// reset clears the control state and entry_count; the table itself is not cleared
// the receiver cannot stall, so a result never holds up the next command
`include "sorted_table_binary_search_assert.svh"

module sorted_table_binary_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic [stbs_pkg::INDEX_W-1:0] entry_index,
	input  logic [stbs_pkg::KEY_W-1:0]   entry_id,
	input  logic [stbs_pkg::KEY_W-1:0]   search_id,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0] cfg_data,
	output logic                         done,
	output logic                         found,
	output logic [stbs_pkg::INDEX_W-1:0] match_index
);
	import stbs_pkg::*;

	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   entry_count_q;
	span_t                lo_q, lo_d;
	span_t                hp1_q, hp1_d;
	addr_t                mid_q, mid_d;
	id_t                  key_q, key_d;
	logic                 done_q, done_d;
	logic                 found_q, found_d;
	logic [INDEX_W-1:0]   match_index_q, match_index_d;
	span_t                cnt;
	logic                 load_in_range;
	logic                 wr_en;
	id_t                  rd_data;
	logic                 search_go;

	assign cnt = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? DEPTH_SPAN : span_t'(entry_count_q);
	assign load_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
	assign search_go = start && !busy && (action == ACT_SEARCH) && (cnt != '0);

	stbs_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_t'(entry_index)),
		.wr_data (id_t'(entry_id)),
		.rd_addr (mid_d),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d       = state_q;
		lo_d          = lo_q;
		hp1_d         = hp1_q;
		mid_d         = mid_q;
		key_d         = key_q;
		done_d        = 1'b0;
		found_d       = found_q;
		match_index_d = match_index_q;
		wr_en         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_LOAD) begin
						wr_en = load_in_range;
					end else begin
						key_d = id_t'(search_id);
						lo_d  = '0;
						hp1_d = cnt;
						mid_d = mid_of(span_t'(0), cnt);
						if (cnt == '0) begin
							done_d        = 1'b1;
							found_d       = 1'b0;
							match_index_d = '0;
						end else begin
							state_d = ST_PROBE;
						end
					end
				end
			end
			ST_PROBE: begin
				if (rd_data == key_q) begin
					done_d        = 1'b1;
					found_d       = 1'b1;
					match_index_d = INDEX_W'(mid_q);
					state_d       = ST_IDLE;
				end else begin
					if (rd_data < key_q) begin
						lo_d = span_t'(mid_q) + span_t'(1);
					end else begin
						hp1_d = span_t'(mid_q);
					end
					if (lo_d < hp1_d) begin
						mid_d = mid_of(lo_d, hp1_d);
					end else begin
						done_d        = 1'b1;
						found_d       = 1'b0;
						match_index_d = '0;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			entry_count_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_valid && cfg_ready) begin
				entry_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q          <= lo_d;
		hp1_q         <= hp1_d;
		mid_q         <= mid_d;
		key_q         <= key_d;
		found_q       <= found_d;
		match_index_q <= match_index_d;
	end

	assign busy        = (state_q == ST_PROBE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign found       = found_q;
	assign match_index = match_index_q;

	`STBS_ASSERT_IMP(a_window_open, clk, arst_n, busy, lo_q < hp1_q, "empty window while probing")
	`STBS_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !found, match_index == '0, "miss with index")
	`STBS_ASSERT_IMP(a_hit_probe, clk, arst_n, done && found, $past(rd_data == key_q), "bad hit")
	`STBS_ASSERT_NEXT(a_search_busy, clk, arst_n, search_go, busy, "search did not start")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import stbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_ITEMS    = 8;

	typedef struct packed {
		logic               action;
		logic [INDEX_W-1:0] entry_index;
		id_t                entry_id;
		id_t                search_id;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] match_index;
	} lookup_res_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		cmd_t               cmd;
		logic               typed;
		lookup_res_t        res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [INDEX_W-1:0] entry_index;
	logic [KEY_W-1:0]   entry_id;
	logic [KEY_W-1:0]   search_id;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data;
	logic               done;
	logic               found;
	logic [INDEX_W-1:0] match_index;

	id_t                shadow_ids [TABLE_DEPTH];
	logic [COUNT_W-1:0] shadow_count;
	lookup_res_t        pending_lookups [$];

	int idle_pct;
	int idle_cycles;
	int errors;
	int n_loads;
	int n_lookups;
	int n_hits;
	int n_settings;

	int phase_counts [12] = '{1, 2, 3, 7, 64, 1023, 2047, 0, 5, 511, 1000, 1024};

	// count, command, typed expectation
	dir_row_t directed_rows [19] = '{
		'{11'd0, '{ACT_SEARCH, 10'd0, 32'd0, 32'd0}, 1'b1, '{1'b0, 10'd0}},
		'{11'd0, '{ACT_SEARCH, 10'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 10'd0}},
		'{11'd0, '{ACT_LOAD, 10'd0, 32'd0, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd0, '{ACT_LOAD, 10'd1, 32'd7, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd0, '{ACT_LOAD, 10'd2, 32'd100, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd0, '{ACT_LOAD, 10'd3, 32'hFFFF_FFFF, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd0, '{ACT_LOAD, 10'd1023, 32'h5A5A_5A5A, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd1, '{ACT_SEARCH, 10'd0, 32'd0, 32'd0}, 1'b1, '{1'b1, 10'd0}},
		'{11'd1, '{ACT_SEARCH, 10'd0, 32'd0, 32'd7}, 1'b1, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1, '{1'b1, 10'd3}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'd7}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'd100}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'd50}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'hFFFF_FFFE}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_LOAD, 10'd2, 32'd3, 32'd0}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'd3}, 1'b0, '{1'b0, 10'd0}},
		'{11'd4, '{ACT_SEARCH, 10'd0, 32'd0, 32'd7}, 1'b0, '{1'b0, 10'd0}},
		'{11'd3, '{ACT_SEARCH, 10'd0, 32'd0, 32'hFFFF_FFFF}, 1'b0, '{1'b0, 10'd0}}
	};

	sorted_table_binary_search u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.entry_index (entry_index),
		.entry_id    (entry_id),
		.search_id   (search_id),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.found       (found),
		.match_index (match_index)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int covered_entries();
		return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
	endfunction

	function automatic lookup_res_t lookup_id(id_t key);
		lookup_res_t r;
		int lo;
		int hi;
		int mid;
		r = '0;
		lo = 0;
		hi = covered_entries() - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (shadow_ids[mid] == key) begin
				r.found = 1'b1;
				r.match_index = INDEX_W'(mid);
				return r;
			end
			if (shadow_ids[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return r;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int n;
		int sel;
		int i;
		id_t lo_v;
		id_t hi_v;
		id_t tmp;
		n = covered_entries();
		c.entry_index = INDEX_W'($urandom);
		c.entry_id = $urandom;
		c.search_id = $urandom;
		sel = $urandom_range(99);
		if (sel < 20) begin
			c.action = ACT_LOAD;
			if (sel >= 2) begin
				// keep the table in order: new value lies between its neighbours
				i = c.entry_index;
				lo_v = (i > 0) ? shadow_ids[i-1] : '0;
				hi_v = (i < TABLE_DEPTH - 1) ? shadow_ids[i+1] : '1;
				if (lo_v > hi_v) begin
					tmp = lo_v;
					lo_v = hi_v;
					hi_v = tmp;
				end
				c.entry_id = $urandom_range(hi_v, lo_v);
			end
		end else begin
			c.action = ACT_SEARCH;
			if (n > 0 && sel < 75)
				c.search_id = shadow_ids[$urandom_range(n - 1)];
			else if (n > 0 && sel < 90)
				c.search_id = shadow_ids[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
			else if (sel < 93)
				c.search_id = '0;
			else if (sel < 96)
				c.search_id = '1;
		end
		return c;
	endfunction

	task automatic issue(cmd_t c, logic typed, lookup_res_t typed_res);
		lookup_res_t r;
		start <= 1'b1;
		action <= c.action;
		entry_index <= c.entry_index;
		entry_id <= c.entry_id;
		search_id <= c.search_id;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (c.action == ACT_LOAD) begin
			shadow_ids[c.entry_index] = c.entry_id;
			n_loads++;
		end else begin
			r = typed ? typed_res : lookup_id(c.search_id);
			pending_lookups.push_back(r);
			n_lookups++;
			if (r.found)
				n_hits++;
		end
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic set_entry_count(logic [COUNT_W-1:0] n);
		start <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_count = n;
		n_settings++;
	endtask

	// result checking and watchdog count
	always @(posedge clk) begin
		lookup_res_t e;
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				$error("unexpected result: found %0d match_index %0d", found, match_index);
				errors++;
			end else begin
				e = pending_lookups.pop_front();
				if (found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, found);
					errors++;
				end
				if (match_index !== e.match_index) begin
					$error("match_index: expected %0d, got %0d", e.match_index, match_index);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		id_t v;
		cmd_t c;
		lookup_res_t none;
		none = '0;
		idle_cycles = 0;
		errors = 0;
		n_loads = 0;
		n_lookups = 0;
		n_hits = 0;
		n_settings = 0;
		shadow_count = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_LOAD;
		entry_index <= '0;
		entry_id <= '0;
		search_id <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		foreach (directed_rows[k]) begin
			if (directed_rows[k].count != shadow_count)
				set_entry_count(directed_rows[k].count);
			issue(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].res);
		end

		// fill the whole table in ascending order, with the odd duplicate
		v = $urandom_range(255);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			c.action = ACT_LOAD;
			c.entry_index = INDEX_W'(i);
			c.entry_id = v;
			c.search_id = $urandom;
			issue(c, 1'b0, none);
			v = v + (($urandom_range(15) == 0) ? 0 : $urandom_range(4194000, 1));
		end

		foreach (phase_counts[p]) begin
			idle_pct = (p < 4) ? 30 : (p < 8) ? 76 : 0;
			set_entry_count(COUNT_W'(phase_counts[p]));
			for (int i = 0; i < PHASE_ITEMS; i++)
				issue(random_cmd(), 1'b0, none);
		end

		start <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			$error("%0d lookups never answered", pending_lookups.size());
			errors++;
		end
		$display("run covered %0d loads and %0d lookups (%0d expected hits)", n_loads, n_lookups,
			n_hits);
		$display("over %0d entry_count settings, %0d mismatches", n_settings, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stbs_pkg.sv
rtl/stbs_table.sv
rtl/sorted_table_binary_search.sv
tb/tb_top.sv
